[hw/rtl/poi_pkg.sv]
// Shared types and constants for the planar odometry integrator.
// Holds the datapath command set, item/result records and the CORDIC arctangent table.
// No dependencies.
package poi_pkg;

    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam int HALF_PI_Q13 = 12868;
    // 2pi in Q13 is 16 * 3217: the index divides by 3217 after the factor 16 is taken out
    localparam int IDX_DIVISOR = TWO_PI_Q13 / 16;
    // Rounding half of 2pi, scaled the same way and rounded down
    localparam int IDX_BIAS    = TWO_PI_Q13 / 32;

    localparam int CORDIC_ITERS  = 16;
    localparam int CORDIC_ITER_W = 4;
    localparam int CORDIC_W      = 33;
    localparam int CORDIC_GAIN_Q30 = 652032875;

    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 112;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ANGLE,
        OP_INDEX,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_FOLD,
        OP_MUL_VXC,
        OP_MUL_VYS,
        OP_MUL_VXS,
        OP_MUL_VYC,
        OP_MUL_TXD,
        OP_MUL_TYD,
        OP_MUL_RD,
        OP_HEAD
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [CORDIC_ITER_W-1:0] iter;
        logic                     publish;
    } cmd_t;

    typedef struct packed {
        logic set_mode;
    } status_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] body_vel_x;
        logic signed [15:0] body_vel_y;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] elapsed;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic signed [15:0] set_heading;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [15:0] world_vel_x;
        logic signed [15:0] world_vel_y;
    } result_t;

    // Arctangent of 2^-i as a fraction of a turn, 2^32 per turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(
        input logic [CORDIC_ITER_W-1:0] iter
    );
        logic signed [CORDIC_W-1:0] val;
        case (iter)
            4'd0:    val = 33'sd536870912;
            4'd1:    val = 33'sd316933406;
            4'd2:    val = 33'sd167458907;
            4'd3:    val = 33'sd85004756;
            4'd4:    val = 33'sd42667331;
            4'd5:    val = 33'sd21354465;
            4'd6:    val = 33'sd10679838;
            4'd7:    val = 33'sd5340245;
            4'd8:    val = 33'sd2670163;
            4'd9:    val = 33'sd1335087;
            4'd10:   val = 33'sd667544;
            4'd11:   val = 33'sd333772;
            4'd12:   val = 33'sd166886;
            4'd13:   val = 33'sd83443;
            4'd14:   val = 33'sd41722;
            default: val = 33'sd20861;
        endcase
        return val;
    endfunction

endpackage

[hw/rtl/poi_datapath.sv]
// Datapath of the planar odometry integrator: pose registers, angle-index reciprocal
// multiplier, CORDIC unit and one shared multiplier, all stepped by commands from poi_ctrl.
// Depends on poi_pkg.
module poi_datapath #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  poi_pkg::cmd_t     cmd,
    input  poi_pkg::item_t    item,
    output poi_pkg::status_t  status,
    output poi_pkg::result_t  result
);

    localparam int IdxW   = SINE_TABLE_BITS;
    localparam int NumW   = IdxW + 13;
    localparam int RecW   = NumW + 1;
    localparam int RecSh  = NumW + 12;
    localparam int ZShift = 32 - IdxW;
    localparam int CW     = poi_pkg::CORDIC_W;

    // Rounded-up reciprocal of the index divisor, exact for every numerator below 2^NumW
    localparam longint RecipL = ((64'sd1 <<< RecSh) + poi_pkg::IDX_DIVISOR - 1)
                                / poi_pkg::IDX_DIVISOR;
    localparam logic [RecW-1:0] Recip = RecW'(RecipL);

    localparam logic signed [17:0] HalfPi = 18'(poi_pkg::HALF_PI_Q13);
    localparam logic signed [17:0] Pi18   = 18'(poi_pkg::PI_Q13);
    localparam logic signed [17:0] TwoPi  = 18'(poi_pkg::TWO_PI_Q13);

    // Pose and flags (reset)
    logic               mode_reg, mode_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [15:0] head_reg, head_next;

    // Working registers (no reset)
    logic signed [15:0] vx_reg, vx_next;
    logic signed [15:0] vy_reg, vy_next;
    logic signed [15:0] rate_reg, rate_next;
    logic signed [15:0] dt_reg, dt_next;
    logic [NumW-1:0]    num_reg, num_next;
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [CW-1:0] cx_reg, cx_next;
    logic signed [CW-1:0] cy_reg, cy_next;
    logic signed [CW-1:0] cz_reg, cz_next;
    logic signed [15:0] cs_reg, cs_next;
    logic signed [15:0] sn_reg, sn_next;
    logic signed [33:0] prod_reg, prod_next;
    logic signed [33:0] acc_reg, acc_next;
    logic signed [17:0] tx_reg, tx_next;
    logic signed [17:0] ty_reg, ty_next;
    logic signed [15:0] wvx_reg, wvx_next;
    logic signed [15:0] wvy_reg, wvy_next;

    // Angle to table index
    logic signed [17:0]    a_w;
    logic signed [17:0]    a_fold;
    logic [15:0]           a_p;
    logic [NumW-1:0]       num_w;
    logic [NumW+RecW-1:0]  idx_prod;
    logic [IdxW-1:0]       idx;

    // CORDIC
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] atan;
    logic signed [33:0]   c_rnd;
    logic signed [33:0]   s_rnd;
    logic signed [15:0]   c16;
    logic signed [15:0]   s16;

    // Multiplier and accumulation
    logic signed [17:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [33:0] product;
    logic signed [34:0] acc35;
    logic signed [34:0] prod35;
    logic signed [34:0] sub_rnd;
    logic signed [34:0] add_rnd;
    logic signed [34:0] p_rnd;
    logic signed [34:0] h_rnd;
    logic signed [23:0] p_step;
    logic signed [31:0] pos_cur;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [17:0] h_step;
    logic signed [17:0] h_sum;
    logic signed [17:0] h_wrap;
    logic signed [15:0] wvx_sat;
    logic signed [15:0] wvy_sat;

    assign a_w    = HalfPi - {{2{head_reg[15]}}, head_reg};
    assign a_fold = a_w[17] ? (a_w + TwoPi) : a_w;
    assign a_p    = a_fold[15:0];

    // Index = round(a * 2^IdxW / 2pi) with the factor 16 of 2pi moved into the numerator
    assign num_w    = (NumW'(a_p) << (IdxW - 4)) + NumW'(poi_pkg::IDX_BIAS);
    assign idx_prod = num_reg * Recip;
    assign idx      = idx_prod[RecSh+IdxW-1:RecSh];

    assign dx   = cy_reg >>> cmd.iter;
    assign dy   = cx_reg >>> cmd.iter;
    assign atan = poi_pkg::atan_turn(cmd.iter);

    assign c_rnd = {cx_reg[CW-1], cx_reg} + 34'sd65536;
    assign s_rnd = {cy_reg[CW-1], cy_reg} + 34'sd65536;
    assign c16   = c_rnd[32:17];
    assign s16   = s_rnd[32:17];

    always_comb begin
        case (cmd.op)
            poi_pkg::OP_MUL_VXC: begin
                mul_a = {{2{vx_reg[15]}}, vx_reg};
                mul_b = cs_reg;
            end
            poi_pkg::OP_MUL_VYS: begin
                mul_a = {{2{vy_reg[15]}}, vy_reg};
                mul_b = sn_reg;
            end
            poi_pkg::OP_MUL_VXS: begin
                mul_a = {{2{vx_reg[15]}}, vx_reg};
                mul_b = sn_reg;
            end
            poi_pkg::OP_MUL_VYC: begin
                mul_a = {{2{vy_reg[15]}}, vy_reg};
                mul_b = cs_reg;
            end
            poi_pkg::OP_MUL_TXD: begin
                mul_a = tx_reg;
                mul_b = dt_reg;
            end
            poi_pkg::OP_MUL_TYD: begin
                mul_a = ty_reg;
                mul_b = dt_reg;
            end
            default: begin
                mul_a = {{2{rate_reg[15]}}, rate_reg};
                mul_b = dt_reg;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    assign acc35   = {acc_reg[33], acc_reg};
    assign prod35  = {prod_reg[33], prod_reg};
    assign sub_rnd = acc35 - prod35 + 35'sd4096;
    assign add_rnd = acc35 + prod35 + 35'sd4096;

    // Position step: round the Q27 product to Q16, add and saturate
    assign p_rnd   = prod35 + 35'sd1024;
    assign p_step  = p_rnd[34:11];
    assign pos_cur = (cmd.op == poi_pkg::OP_MUL_TYD) ? x_reg : y_reg;
    assign pos_sum = {pos_cur[31], pos_cur} + {{9{p_step[23]}}, p_step};
    always_comb begin
        if (pos_sum[32] != pos_sum[31]) begin
            pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            pos_sat = pos_sum[31:0];
        end
    end

    // Heading step: round the Q28 product to Q13, add and wrap once
    assign h_rnd  = prod35 + 35'sd16384;
    assign h_step = h_rnd[32:15];
    assign h_sum  = {{2{head_reg[15]}}, head_reg} + h_step;
    always_comb begin
        if (h_sum < -Pi18) begin
            h_wrap = h_sum + TwoPi;
        end else if (h_sum > Pi18) begin
            h_wrap = h_sum - TwoPi;
        end else begin
            h_wrap = h_sum;
        end
    end

    always_comb begin
        if (tx_reg > 18'sd32767) begin
            wvx_sat = 16'sh7FFF;
        end else if (tx_reg < -18'sd32768) begin
            wvx_sat = 16'sh8000;
        end else begin
            wvx_sat = tx_reg[15:0];
        end
        if (ty_reg > 18'sd32767) begin
            wvy_sat = 16'sh7FFF;
        end else if (ty_reg < -18'sd32768) begin
            wvy_sat = 16'sh8000;
        end else begin
            wvy_sat = ty_reg[15:0];
        end
    end

    always_comb begin
        mode_next = mode_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        head_next = head_reg;
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        rate_next = rate_reg;
        dt_next   = dt_reg;
        num_next  = num_reg;
        idx_next  = idx_reg;
        quad_next = quad_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cz_next   = cz_reg;
        cs_next   = cs_reg;
        sn_next   = sn_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        tx_next   = tx_reg;
        ty_next   = ty_reg;
        wvx_next  = wvx_reg;
        wvy_next  = wvy_reg;
        case (cmd.op)
            poi_pkg::OP_CAPTURE: begin
                mode_next = item.mode;
                vx_next   = item.body_vel_x;
                vy_next   = item.body_vel_y;
                rate_next = item.yaw_rate;
                dt_next   = item.elapsed;
                // Load the pose straight away in set mode
                if (item.mode) begin
                    x_next    = item.set_x;
                    y_next    = item.set_y;
                    head_next = item.set_heading;
                    wvx_next  = '0;
                    wvy_next  = '0;
                end
            end
            poi_pkg::OP_ANGLE: begin
                num_next = num_w;
            end
            poi_pkg::OP_INDEX: begin
                idx_next = idx;
            end
            poi_pkg::OP_CORDIC_INIT: begin
                quad_next = idx_reg[IdxW-1:IdxW-2];
                cx_next   = CW'(poi_pkg::CORDIC_GAIN_Q30);
                cy_next   = '0;
                cz_next   = $signed(CW'(idx_reg[IdxW-3:0]) << ZShift);
            end
            poi_pkg::OP_CORDIC_STEP: begin
                if (cz_reg[CW-1]) begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + atan;
                end else begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - atan;
                end
            end
            poi_pkg::OP_FOLD: begin
                case (quad_reg)
                    2'd0: begin
                        cs_next = c16;
                        sn_next = s16;
                    end
                    2'd1: begin
                        cs_next = -s16;
                        sn_next = c16;
                    end
                    2'd2: begin
                        cs_next = -c16;
                        sn_next = -s16;
                    end
                    default: begin
                        cs_next = s16;
                        sn_next = -c16;
                    end
                endcase
            end
            poi_pkg::OP_MUL_VXC: begin
                prod_next = product;
            end
            poi_pkg::OP_MUL_VYS: begin
                acc_next  = prod_reg;
                prod_next = product;
            end
            poi_pkg::OP_MUL_VXS: begin
                tx_next   = sub_rnd[30:13];
                prod_next = product;
            end
            poi_pkg::OP_MUL_VYC: begin
                acc_next  = prod_reg;
                prod_next = product;
            end
            poi_pkg::OP_MUL_TXD: begin
                ty_next   = -$signed(add_rnd[30:13]);
                prod_next = product;
            end
            poi_pkg::OP_MUL_TYD: begin
                x_next    = pos_sat;
                prod_next = product;
            end
            poi_pkg::OP_MUL_RD: begin
                y_next    = pos_sat;
                prod_next = product;
            end
            poi_pkg::OP_HEAD: begin
                head_next = h_wrap[15:0];
                wvx_next  = wvx_sat;
                wvy_next  = wvy_sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            x_reg    <= '0;
            y_reg    <= '0;
            head_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        rate_reg <= rate_next;
        dt_reg   <= dt_next;
        num_reg  <= num_next;
        idx_reg  <= idx_next;
        quad_reg <= quad_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        cz_reg   <= cz_next;
        cs_reg   <= cs_next;
        sn_reg   <= sn_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        wvx_reg  <= wvx_next;
        wvy_reg  <= wvy_next;
    end

    assign status.set_mode = mode_reg;

    assign result.pos_x       = x_reg;
    assign result.pos_y       = y_reg;
    assign result.heading     = head_reg;
    assign result.world_vel_x = wvx_reg;
    assign result.world_vel_y = wvy_reg;

endmodule

[hw/rtl/poi_ctrl.sv]
// Sequencer of the planar odometry integrator: walks an integrate transaction through
// capture, table-index computation, CORDIC, the multiply schedule and publication.
// Depends on poi_pkg.
module poi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic             out_free,
    input  poi_pkg::status_t status,
    output logic             in_ready,
    output poi_pkg::cmd_t    cmd
);

    localparam int CntW = $clog2(poi_pkg::CORDIC_ITERS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INDEX,
        ST_CINIT,
        ST_CORDIC,
        ST_FOLD,
        ST_VXC,
        ST_VYS,
        ST_VXS,
        ST_VYC,
        ST_TXD,
        ST_TYD,
        ST_RD,
        ST_HEAD,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.op      = poi_pkg::OP_NONE;
        cmd.iter    = cnt_reg[poi_pkg::CORDIC_ITER_W-1:0];
        cmd.publish = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.op     = poi_pkg::OP_CAPTURE;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                // Set mode already loaded the pose at capture
                if (status.set_mode) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = poi_pkg::OP_ANGLE;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX: begin
                cmd.op     = poi_pkg::OP_INDEX;
                state_next = ST_CINIT;
            end
            ST_CINIT: begin
                cmd.op     = poi_pkg::OP_CORDIC_INIT;
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.op = poi_pkg::OP_CORDIC_STEP;
                if (cnt_reg == CntW'(poi_pkg::CORDIC_ITERS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FOLD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FOLD: begin
                cmd.op     = poi_pkg::OP_FOLD;
                state_next = ST_VXC;
            end
            ST_VXC: begin
                cmd.op     = poi_pkg::OP_MUL_VXC;
                state_next = ST_VYS;
            end
            ST_VYS: begin
                cmd.op     = poi_pkg::OP_MUL_VYS;
                state_next = ST_VXS;
            end
            ST_VXS: begin
                cmd.op     = poi_pkg::OP_MUL_VXS;
                state_next = ST_VYC;
            end
            ST_VYC: begin
                cmd.op     = poi_pkg::OP_MUL_VYC;
                state_next = ST_TXD;
            end
            ST_TXD: begin
                cmd.op     = poi_pkg::OP_MUL_TXD;
                state_next = ST_TYD;
            end
            ST_TYD: begin
                cmd.op     = poi_pkg::OP_MUL_TYD;
                state_next = ST_RD;
            end
            ST_RD: begin
                cmd.op     = poi_pkg::OP_MUL_RD;
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                cmd.op     = poi_pkg::OP_HEAD;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register can take the result
                if (out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hw/rtl/planar_odometry_integrator_core.sv]
// Top level of the planar odometry integrator: stream ports, output register,
// sequencer and datapath. Depends on poi_pkg, poi_ctrl and poi_datapath.
//
//   Channel | Direction | Payload
//   s_*     | in        | tuser: mode; tdata: body velocity, yaw rate, elapsed, pose to load
//   m_*     | out       | tdata: position, heading, world velocity
//
// An integrate transaction runs from accept to the next accept through capture, the
// table index (numerator, then reciprocal multiply), CORDIC setup, 16 CORDIC steps,
// the quadrant fold, seven passes through the single shared multiplier, the heading
// update and publication, held for a free output register; set mode skips straight to it.
// The finished result sits in the output register, so a new transaction is accepted
// while m_tready is low; only the next result waits for that register to drain.
// Synchronous reset clears the pose to zero and drops any pending result.
module planar_odometry_integrator_core #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] body_vel_x, [31:16] body_vel_y, [47:32] yaw_rate, [63:48] elapsed,
    // [95:64] set_x, [127:96] set_y, [143:128] set_heading
    input  logic [poi_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] mode
    input  logic [0:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] pos_x, [63:32] pos_y, [79:64] heading, [95:80] world_vel_x,
    // [111:96] world_vel_y
    output logic [poi_pkg::M_TDATA_W-1:0]   m_tdata
);

    poi_pkg::cmd_t    cmd;
    poi_pkg::status_t status;
    poi_pkg::item_t   item;
    poi_pkg::result_t res;

    logic                          out_free;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [poi_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    assign item.mode        = s_tuser[0];
    assign item.body_vel_x  = s_tdata[15:0];
    assign item.body_vel_y  = s_tdata[31:16];
    assign item.yaw_rate    = s_tdata[47:32];
    assign item.elapsed     = s_tdata[63:48];
    assign item.set_x       = s_tdata[95:64];
    assign item.set_y       = s_tdata[127:96];
    assign item.set_heading = s_tdata[143:128];

    assign out_free = !m_tvalid_reg || m_tready;

    poi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    poi_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .item    (item),
        .status  (status),
        .result  (res)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (cmd.publish) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.world_vel_y, res.world_vel_x, res.heading,
                             res.pos_y, res.pos_x};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[test/planar_odometry_integrator_core_tb.sv]
// Self-checking testbench for planar_odometry_integrator_core: random and directed
// pose-update transactions, with a scoreboard that predicts every pose and world velocity.
// Depends on poi_pkg and the core RTL.
module planar_odometry_integrator_core_tb;

    localparam int TABLE_BITS   = 10;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_HOLD    = 400;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SETTLE       = 64;

    localparam logic MODE_INTEGRATE = 1'b0;
    localparam logic MODE_LOAD      = 1'b1;

    localparam longint PI_Q       = 25736;
    localparam longint TWO_PI_Q   = 51472;
    localparam longint HALF_PI_Q  = 12868;
    localparam longint GAIN_Q30   = 652032875;
    localparam longint I32_MIN    = -(64'sd1 <<< 31);
    localparam longint I32_MAX    = (64'sd1 <<< 31) - 1;

    class pose_scoreboard;
        poi_pkg::result_t expected_poses[$];
        int errors;
        logic signed [31:0] x_q16;
        logic signed [31:0] y_q16;
        logic signed [15:0] head_q13;
        longint atan_q32[16] = '{
            536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861
        };

        function new();
            errors = 0;
            x_q16 = '0;
            y_q16 = '0;
            head_q13 = '0;
        endfunction

        function longint rnd(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // Quantize the angle to a table index, fold to the first quadrant, run CORDIC
        function void unit_vector(input longint ang, output longint cs, output longint sn);
            longint u, idx, quad, x, y, z, dx, dy, c, s;
            u = ang + 4 * TWO_PI_Q;
            idx = (((u <<< (TABLE_BITS + 1)) + TWO_PI_Q) / (2 * TWO_PI_Q))
                  & ((64'sd1 <<< TABLE_BITS) - 1);
            quad = idx >>> (TABLE_BITS - 2);
            z = (idx & ((64'sd1 <<< (TABLE_BITS - 2)) - 1)) <<< (32 - TABLE_BITS);
            x = GAIN_Q30;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q32[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q32[i];
                end
            end
            c = rnd(x, 17);
            s = rnd(y, 17);
            case (quad)
                0: begin cs = c;  sn = s;  end
                1: begin cs = -s; sn = c;  end
                2: begin cs = -c; sn = -s; end
                default: begin cs = s; sn = -c; end
            endcase
        endfunction

        function void note_item(poi_pkg::item_t it);
            longint vx, vy, rate, dt, cs, sn, tx, ty, h;
            poi_pkg::result_t want;
            if (it.mode == MODE_LOAD) begin
                x_q16 = it.set_x;
                y_q16 = it.set_y;
                head_q13 = it.set_heading;
                want.world_vel_x = '0;
                want.world_vel_y = '0;
            end else begin
                vx = it.body_vel_x;
                vy = it.body_vel_y;
                rate = it.yaw_rate;
                dt = it.elapsed;
                unit_vector(HALF_PI_Q - longint'(head_q13), cs, sn);
                tx = rnd(vx * cs - vy * sn, 13);
                ty = -rnd(vx * sn + vy * cs, 13);
                x_q16 = clamp(longint'(x_q16) + rnd(tx * dt, 11), I32_MIN, I32_MAX);
                y_q16 = clamp(longint'(y_q16) + rnd(ty * dt, 11), I32_MIN, I32_MAX);
                h = longint'(head_q13) + rnd(rate * dt, 15);
                if (h < -PI_Q)
                    h = h + TWO_PI_Q;
                else if (h > PI_Q)
                    h = h - TWO_PI_Q;
                head_q13 = h;
                want.world_vel_x = clamp(tx, -32768, 32767);
                want.world_vel_y = clamp(ty, -32768, 32767);
            end
            want.pos_x = x_q16;
            want.pos_y = y_q16;
            want.heading = head_q13;
            expected_poses.push_back(want);
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got) begin
                $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(poi_pkg::result_t got);
            poi_pkg::result_t want;
            if (expected_poses.size() == 0) begin
                $display("%0t unexpected result: expected none, actual pos_x %0d pos_y %0d",
                         $time, got.pos_x, got.pos_y);
                errors++;
                return;
            end
            want = expected_poses.pop_front();
            compare("pos_x", want.pos_x, got.pos_x);
            compare("pos_y", want.pos_y, got.pos_y);
            compare("heading", want.heading, got.heading);
            compare("world_vel_x", want.world_vel_x, got.world_vel_x);
            compare("world_vel_y", want.world_vel_y, got.world_vel_y);
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [poi_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [0:0]                      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [poi_pkg::M_TDATA_W-1:0]   m_tdata;

    logic                   quiet = 1'b0;
    int                     hold_tag = 0;
    int                     rx_seen_tag = 0;
    int                     rx_stall_left = 0;
    int                     cycle_count = 0;
    pose_scoreboard         sb;

    planar_odometry_integrator_core #(
        .SINE_TABLE_BITS(TABLE_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next m_tready
    always @(posedge aclk) begin : rx_side
        poi_pkg::result_t got;
        if (m_tvalid && m_tready) begin
            got.pos_x = m_tdata[31:0];
            got.pos_y = m_tdata[63:32];
            got.heading = m_tdata[79:64];
            got.world_vel_x = m_tdata[95:80];
            got.world_vel_y = m_tdata[111:96];
            sb.check_result(got);
        end
        if (hold_tag != rx_seen_tag) begin
            rx_seen_tag = hold_tag;
            rx_stall_left = LONG_HOLD;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [15:0] rand16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand32();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic poi_pkg::item_t rand_item();
        poi_pkg::item_t it;
        it.mode = ($urandom_range(0, 9) == 0) ? MODE_LOAD : MODE_INTEGRATE;
        it.body_vel_x = rand16();
        it.body_vel_y = rand16();
        it.yaw_rate = rand16();
        it.elapsed = rand16();
        it.set_x = rand32();
        it.set_y = rand32();
        it.set_heading = int'($urandom_range(0, 2 * PI_Q)) - int'(PI_Q);
        return it;
    endfunction

    function automatic poi_pkg::item_t mk_move(int vx, int vy, int rate, int dt);
        poi_pkg::item_t it;
        it = rand_item();
        it.mode = MODE_INTEGRATE;
        it.body_vel_x = vx;
        it.body_vel_y = vy;
        it.yaw_rate = rate;
        it.elapsed = dt;
        return it;
    endfunction

    function automatic poi_pkg::item_t mk_pose(logic [31:0] x, logic [31:0] y, int h);
        poi_pkg::item_t it;
        it = rand_item();
        it.mode = MODE_LOAD;
        it.set_x = x;
        it.set_y = y;
        it.set_heading = h;
        return it;
    endfunction

    // Keep tvalid high across back-to-back transactions; lower it only for a gap
    task automatic offer_item(input poi_pkg::item_t it);
        int gap;
        s_tdata <= {it.set_heading, it.set_y, it.set_x, it.elapsed, it.yaw_rate,
                    it.body_vel_y, it.body_vel_x};
        s_tuser <= it.mode;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes from the reset pose, negative and zero elapsed
        offer_item(mk_move(32767, 0, 0, 32767));
        offer_item(mk_move(0, 32767, 32767, 32767));
        offer_item(mk_move(-32768, -32768, -32768, 32767));
        offer_item(mk_move(12000, -7000, 4000, -32768));
        offer_item(mk_move(32767, 32767, 32767, 0));
        // Headings at pi and -pi, wrapping below -pi, with saturating positions
        offer_item(mk_pose(32'h7fff_ffff, 32'h8000_0000, 25736));
        offer_item(mk_move(32767, 32767, 1, 16));
        offer_item(mk_pose(32'h8000_0000, 32'h7fff_ffff, -25736));
        offer_item(mk_move(-32768, 32767, -1, 32767));
        // Quarter-pi headings push the world velocity past 16 bits
        offer_item(mk_pose(32'h0, 32'h0, 6434));
        offer_item(mk_move(32767, -32768, 0, 32767));
        offer_item(mk_pose(32'h0, 32'h0, -6434));
        offer_item(mk_move(-32768, 32767, 0, -32768));
        offer_item(mk_pose(32'h7fff_ffff, 32'h7fff_ffff, 0));
        offer_item(mk_move(32767, 0, 0, 32767));
        offer_item(mk_move(-32768, 0, 0, 32767));
        offer_item(mk_pose(32'h8000_0000, 32'h8000_0000, 12868));
        offer_item(mk_move(-32768, -32768, 32767, 32767));
        offer_item(mk_move(32767, 32767, -32768, -32768));
        offer_item(mk_pose(32'h0, 32'h0, -12868));
        offer_item(mk_move(0, 0, 0, 0));
        offer_item(mk_move(-1, 1, -1, 1));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                hold_tag <= hold_tag + 1;
            if (n == 600) begin
                // Drain the pipeline before sending more
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
            end
            if (n == 1000)
                quiet <= 1'b1;
            offer_item(rand_item());
        end
        s_tvalid <= 1'b0;

        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge aclk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/poi_pkg.sv
hw/rtl/poi_datapath.sv
hw/rtl/poi_ctrl.sv
hw/rtl/planar_odometry_integrator_core.sv
test/planar_odometry_integrator_core_tb.sv
